/* rtl/core/lz_pkg.sv */
`timescale 1ns / 1ps
package lz_pkg;

  // Fixed-point format
  localparam int unsigned FX_W    = 32;
  localparam int unsigned FRAC    = 24;
  localparam int unsigned UREG_W  = 31;
  localparam int unsigned COL_W   = 25;
  localparam int unsigned OP_W    = FX_W + 1;
  localparam int unsigned PROD_W  = 2 * OP_W;
  localparam int unsigned SH_W    = PROD_W - FRAC;
  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned STEP_W  = 4;

  localparam logic [COL_W-1:0] COL_ONE = COL_W'(1) << FRAC;
  localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  // Register reset values
  localparam logic [UREG_W-1:0]      SIGMA_RST = 31'd167772160;
  localparam logic [UREG_W-1:0]      RHO_RST   = 31'd469762048;
  localparam logic [UREG_W-1:0]      BETA_RST  = 31'd44738124;
  localparam logic [UREG_W-1:0]      DT_RST    = 31'd16777;
  localparam logic signed [FX_W-1:0] START_RST = 32'sd16777216;
  localparam logic [UREG_W-1:0]      GAIN_RST  = 31'd111848107;

  // Register indexes
  localparam logic [2:0] REG_SIGMA   = 3'd0;
  localparam logic [2:0] REG_RHO     = 3'd1;
  localparam logic [2:0] REG_BETA    = 3'd2;
  localparam logic [2:0] REG_DT      = 3'd3;
  localparam logic [2:0] REG_START_X = 3'd4;
  localparam logic [2:0] REG_START_Y = 3'd5;
  localparam logic [2:0] REG_START_Z = 3'd6;
  localparam logic [2:0] REG_GAIN    = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [UREG_W-1:0]      sigma;
    logic [UREG_W-1:0]      rho;
    logic [UREG_W-1:0]      beta;
    logic [UREG_W-1:0]      time_step;
    logic signed [FX_W-1:0] start_x;
    logic signed [FX_W-1:0] start_y;
    logic signed [FX_W-1:0] start_z;
    logic [UREG_W-1:0]      colour_gain;
  } cfg_t;

  // Saturate a 33-bit sum or difference to the signed word range
  function automatic logic signed [FX_W-1:0] sat_sum(input logic signed [OP_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v[OP_W-1] != v[OP_W-2]) begin
      r = v[OP_W-1] ? FX_MIN : FX_MAX;
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

  // Floor-shift a full product by the fraction bits and saturate
  function automatic logic signed [FX_W-1:0] fix_mul(input logic signed [PROD_W-1:0] p);
    logic [SH_W-1:0]        sh;
    logic signed [FX_W-1:0] r;
    sh = p[PROD_W-1:FRAC];
    if (sh[SH_W-1] && !(&sh[SH_W-2:FX_W-1])) begin
      r = FX_MIN;
    end else if (!sh[SH_W-1] && (|sh[SH_W-2:FX_W-1])) begin
      r = FX_MAX;
    end else begin
      r = sh[FX_W-1:0];
    end
    return r;
  endfunction

  // Truncate a nonnegative product to a colour value, capped at one
  function automatic logic [COL_W-1:0] col_cap(input logic signed [PROD_W-1:0] p);
    logic [SH_W-1:0]  sh;
    logic [COL_W-1:0] r;
    sh = p[PROD_W-1:FRAC];
    if ((|sh[SH_W-1:COL_W]) || (sh[COL_W-1:0] > COL_ONE)) begin
      r = COL_ONE;
    end else begin
      r = sh[COL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/lz_mul.sv */
`timescale 1ns / 1ps
module lz_mul (
  input  logic                              clk_i,
  input  logic signed [lz_pkg::OP_W-1:0]    op_a_i,
  input  logic signed [lz_pkg::OP_W-1:0]    op_b_i,
  output logic signed [lz_pkg::PROD_W-1:0]  prod_o
);
  import lz_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // Register the full signed product
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/lz_cfg.sv */
`timescale 1ns / 1ps
module lz_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lz_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lz_pkg::cfg_t               cfg_o
);
  import lz_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sigma       <= SIGMA_RST;
      cfg_q.rho         <= RHO_RST;
      cfg_q.beta        <= BETA_RST;
      cfg_q.time_step   <= DT_RST;
      cfg_q.start_x     <= START_RST;
      cfg_q.start_y     <= START_RST;
      cfg_q.start_z     <= START_RST;
      cfg_q.colour_gain <= GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SIGMA:   cfg_q.sigma       <= pwdata[UREG_W-1:0];
        REG_RHO:     cfg_q.rho         <= pwdata[UREG_W-1:0];
        REG_BETA:    cfg_q.beta        <= pwdata[UREG_W-1:0];
        REG_DT:      cfg_q.time_step   <= pwdata[UREG_W-1:0];
        REG_START_X: cfg_q.start_x     <= pwdata;
        REG_START_Y: cfg_q.start_y     <= pwdata;
        REG_START_Z: cfg_q.start_z     <= pwdata;
        REG_GAIN:    cfg_q.colour_gain <= pwdata[UREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (idx)
      REG_SIGMA:   prdata = {1'b0, cfg_q.sigma};
      REG_RHO:     prdata = {1'b0, cfg_q.rho};
      REG_BETA:    prdata = {1'b0, cfg_q.beta};
      REG_DT:      prdata = {1'b0, cfg_q.time_step};
      REG_START_X: prdata = cfg_q.start_x;
      REG_START_Y: prdata = cfg_q.start_y;
      REG_START_Z: prdata = cfg_q.start_z;
      REG_GAIN:    prdata = {1'b0, cfg_q.colour_gain};
      default:     prdata = '0;
    endcase
  end

endmodule

/* rtl/core/lorenz_euler_step_top.sv */
`timescale 1ns / 1ps
// Step word: one shared 33x33 multiplier issues the ten products of a step one per cycle,
// and the sequencer steps on without waiting; the word then passes through ST_FIN to the output.
// Restart word: the point is reloaded on acceptance and the word goes straight to ST_FIN.
// A new word is accepted only in ST_IDLE, after the last one is loaded; output stall holds ST_FIN.
// Reset (asynchronous, active low): default coefficients, point at (1.0, 1.0, 1.0),
// no result pending.
module lorenz_euler_step_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lz_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         pos_x_o,
  output logic signed [31:0]         pos_y_o,
  output logic signed [31:0]         pos_z_o,
  output logic [24:0]                red_o,
  output logic [24:0]                green_o,
  output logic [24:0]                blue_o
);
  import lz_pkg::*;

  // Sequencer steps
  localparam logic [STEP_W-1:0] STEP_DX    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_XU    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_XY    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_BZ    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_IX    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_IY    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_IZ    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RED   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_GREEN = 4'd8;
  localparam logic [STEP_W-1:0] STEP_BLUE  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd10;

  cfg_t   cfg;
  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;

  logic in_fire, load_out, running;
  logic out_valid_q;

  logic signed [FX_W-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic signed [FX_W-1:0] t_q, u_q, dx_q, dy_q, dz_q, mxy_q, ix_q, iy_q, iz_q;
  logic [COL_W-1:0]       red_q, green_q, blue_q;

  logic signed [FX_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [COL_W-1:0]       red_out_q, green_out_q, blue_out_q;

  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [FX_W-1:0]   mres;

  lz_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lz_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign mres = fix_mul(prod);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = restart_i ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    running    = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RUN:  running    = 1'b1;
      ST_FIN:  load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the step counter while running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (in_fire) begin
      step_q <= STEP_DX;
    end else if (running) begin
      step_q <= step_q + 1'b1;
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      STEP_DX: begin
        op_a = {2'b00, cfg.sigma};
        op_b = {t_q[FX_W-1], t_q};
      end
      STEP_XU: begin
        op_a = {cur_x_q[FX_W-1], cur_x_q};
        op_b = {u_q[FX_W-1], u_q};
      end
      STEP_XY: begin
        op_a = {cur_x_q[FX_W-1], cur_x_q};
        op_b = {cur_y_q[FX_W-1], cur_y_q};
      end
      STEP_BZ: begin
        op_a = {2'b00, cfg.beta};
        op_b = {cur_z_q[FX_W-1], cur_z_q};
      end
      STEP_IX: begin
        op_a = {2'b00, cfg.time_step};
        op_b = {dx_q[FX_W-1], dx_q};
      end
      STEP_IY: begin
        op_a = {2'b00, cfg.time_step};
        op_b = {dy_q[FX_W-1], dy_q};
      end
      STEP_IZ: begin
        op_a = {2'b00, cfg.time_step};
        op_b = {dz_q[FX_W-1], dz_q};
      end
      STEP_RED: begin
        op_a = {2'b00, cfg.colour_gain};
        op_b = ix_q[FX_W-1] ? -{ix_q[FX_W-1], ix_q} : {ix_q[FX_W-1], ix_q};
      end
      STEP_GREEN: begin
        op_a = {2'b00, cfg.colour_gain};
        op_b = iy_q[FX_W-1] ? -{iy_q[FX_W-1], iy_q} : {iy_q[FX_W-1], iy_q};
      end
      STEP_BLUE: begin
        op_a = {2'b00, cfg.colour_gain};
        op_b = iz_q[FX_W-1] ? -{iz_q[FX_W-1], iz_q} : {iz_q[FX_W-1], iz_q};
      end
      default: ;
    endcase
  end

  // Hold the current point; reload or update it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= START_RST;
      cur_y_q <= START_RST;
      cur_z_q <= START_RST;
    end else if (in_fire && restart_i) begin
      cur_x_q <= cfg.start_x;
      cur_y_q <= cfg.start_y;
      cur_z_q <= cfg.start_z;
    end else if (running && step_q == STEP_LAST) begin
      cur_x_q <= sat_sum({cur_x_q[FX_W-1], cur_x_q} + {ix_q[FX_W-1], ix_q});
      cur_y_q <= sat_sum({cur_y_q[FX_W-1], cur_y_q} + {iy_q[FX_W-1], iy_q});
      cur_z_q <= sat_sum({cur_z_q[FX_W-1], cur_z_q} + {iz_q[FX_W-1], iz_q});
    end
  end

  // Preload y-x and rho-z on acceptance; write back each product in the step after it issues
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      t_q     <= sat_sum({cur_y_q[FX_W-1], cur_y_q} - {cur_x_q[FX_W-1], cur_x_q});
      u_q     <= sat_sum({2'b00, cfg.rho} - {cur_z_q[FX_W-1], cur_z_q});
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (running) begin
      case (step_q)
        STEP_XU:    dx_q    <= mres;
        STEP_XY:    dy_q    <= sat_sum({mres[FX_W-1], mres} - {cur_y_q[FX_W-1], cur_y_q});
        STEP_BZ:    mxy_q   <= mres;
        STEP_IX:    dz_q    <= sat_sum({mxy_q[FX_W-1], mxy_q} - {mres[FX_W-1], mres});
        STEP_IY:    ix_q    <= mres;
        STEP_IZ:    iy_q    <= mres;
        STEP_RED:   iz_q    <= mres;
        STEP_GREEN: red_q   <= col_cap(prod);
        STEP_BLUE:  green_q <= col_cap(prod);
        STEP_LAST:  blue_q  <= col_cap(prod);
        default: ;
      endcase
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pos_x_q     <= cur_x_q;
      pos_y_q     <= cur_y_q;
      pos_z_q     <= cur_z_q;
      red_out_q   <= red_q;
      green_out_q <= green_q;
      blue_out_q  <= blue_q;
    end
  end

  // Hold output valid until the word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign red_o       = red_out_q;
  assign green_o     = green_out_q;
  assign blue_o      = blue_out_q;

endmodule

/* dv/lorenz_euler_step_top_tb.sv */
`timescale 1ns / 1ps
module lorenz_euler_step_top_tb;
  import lz_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_TICKS    = 64;
  localparam int MAX_WAIT       = 14;
  localparam int SETTLE_CYCLES  = 20;

  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;

  typedef struct {
    logic signed [FX_W-1:0] x;
    logic signed [FX_W-1:0] y;
    logic signed [FX_W-1:0] z;
    logic [COL_W-1:0]       red;
    logic [COL_W-1:0]       green;
    logic [COL_W-1:0]       blue;
  } lz_point_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [CFG_AW-1:0]  paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               restart   = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [24:0]        red;
  logic [24:0]        green;
  logic [24:0]        blue;

  // Predictor state: coefficients and current point of the trajectory
  cfg_t                   coef;
  logic signed [FX_W-1:0] pt_x;
  logic signed [FX_W-1:0] pt_y;
  logic signed [FX_W-1:0] pt_z;

  lz_point_t expected_points[$];
  bit        pending_ticks[$];
  bit        idle_mode   = 1'b1;
  int        hold_seq    = 0;
  int        hold_len    = 0;
  int        hold_seen   = 0;
  int        hold_left   = 0;
  int        tick_gap    = 0;
  int        sink_gap    = 0;
  int        quiet_cycles = 0;
  int        errors      = 0;

  lorenz_euler_step_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .restart_i  (restart),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .pos_x_o    (pos_x),
    .pos_y_o    (pos_y),
    .pos_z_o    (pos_z),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp to the signed word range
  function automatic longint clamp_word(longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Fixed-point product, floor of the shifted value, clamped
  function automatic longint qmul(longint a, longint b);
    return clamp_word((a * b) >>> FRAC);
  endfunction

  // Colour channel: truncated |inc| * gain, capped at one
  function automatic logic [COL_W-1:0] shade(longint inc);
    longint mag;
    longint c;
    mag = (inc < 0) ? -inc : inc;
    c = (mag * longint'(coef.colour_gain)) >>> FRAC;
    if (c > longint'(COL_ONE)) c = longint'(COL_ONE);
    return c[COL_W-1:0];
  endfunction

  // Advance the trajectory by one tick and return the point it emits
  function automatic lz_point_t step_lorenz(bit do_restart);
    lz_point_t res;
    longint    x, y, z, dx, dy, dz, ix, iy, iz;
    x = pt_x;
    y = pt_y;
    z = pt_z;
    res.red   = '0;
    res.green = '0;
    res.blue  = '0;
    if (do_restart) begin
      pt_x = coef.start_x;
      pt_y = coef.start_y;
      pt_z = coef.start_z;
    end else begin
      dx = qmul(longint'(coef.sigma), clamp_word(y - x));
      dy = clamp_word(qmul(x, clamp_word(longint'(coef.rho) - z)) - y);
      dz = clamp_word(qmul(x, y) - qmul(longint'(coef.beta), z));
      ix = qmul(longint'(coef.time_step), dx);
      iy = qmul(longint'(coef.time_step), dy);
      iz = qmul(longint'(coef.time_step), dz);
      pt_x = FX_W'(clamp_word(x + ix));
      pt_y = FX_W'(clamp_word(y + iy));
      pt_z = FX_W'(clamp_word(z + iz));
      res.red   = shade(ix);
      res.green = shade(iy);
      res.blue  = shade(iz);
    end
    res.x = pt_x;
    res.y = pt_y;
    res.z = pt_z;
    return res;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Write one register over the bus and mirror it in the predictor
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIGMA:   coef.sigma       = val[UREG_W-1:0];
      REG_RHO:     coef.rho         = val[UREG_W-1:0];
      REG_BETA:    coef.beta        = val[UREG_W-1:0];
      REG_DT:      coef.time_step   = val[UREG_W-1:0];
      REG_START_X: coef.start_x     = val;
      REG_START_Y: coef.start_y     = val;
      REG_START_Z: coef.start_z     = val;
      REG_GAIN:    coef.colour_gain = val[UREG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_coefs(input logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  // Mostly an attractor-like setting, sometimes anything at all
  task automatic program_random();
    logic [31:0] v [8];
    for (int i = 0; i < 8; i++) v[i] = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      v[REG_SIGMA]   = $urandom_range(0, 20 << FRAC);
      v[REG_RHO]     = $urandom_range(0, 48 << FRAC);
      v[REG_BETA]    = $urandom_range(0, 4 << FRAC);
      v[REG_DT]      = $urandom_range(0, 1 << 19);
      v[REG_START_X] = $urandom_range(0, 60 << FRAC) - (30 << FRAC);
      v[REG_START_Y] = $urandom_range(0, 60 << FRAC) - (30 << FRAC);
      v[REG_START_Z] = $urandom_range(0, 60 << FRAC) - (30 << FRAC);
      v[REG_GAIN]    = $urandom_range(0, 64 << FRAC);
      // exercise the unused top bit of the unsigned registers
      v[REG_SIGMA][31] = 1'($urandom_range(0, 1));
      v[REG_RHO][31]   = 1'($urandom_range(0, 1));
      v[REG_BETA][31]  = 1'($urandom_range(0, 1));
      v[REG_DT][31]    = 1'($urandom_range(0, 1));
      v[REG_GAIN][31]  = 1'($urandom_range(0, 1));
    end
    program_coefs(v);
  endtask

  // Hold until every queued tick is sent and every result is back
  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_points.size() != 0)
      @(negedge clk_i);
  endtask

  // Drive ticks from the pending queue, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      restart  <= 1'b0;
      tick_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_points.push_back(step_lorenz(restart));
        tick_gap = idle_mode ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (!in_valid || in_ready) begin
        if (tick_gap > 0) begin
          tick_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_valid <= 1'b1;
          restart  <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each result word with the oldest prediction, then stall at random
  always @(posedge clk_i) begin
    lz_point_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("result word with no prediction pending");
          errors++;
        end else begin
          want = expected_points.pop_front();
          check_field("pos_x", want.x, pos_x);
          check_field("pos_y", want.y, pos_y);
          check_field("pos_z", want.z, pos_z);
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
        end
        sink_gap = idle_mode ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] v [8];
    coef = '{sigma: SIGMA_RST, rho: RHO_RST, beta: BETA_RST, time_step: DT_RST,
             start_x: START_RST, start_y: START_RST, start_z: START_RST,
             colour_gain: GAIN_RST};
    pt_x = START_RST;
    pt_y = START_RST;
    pt_z = START_RST;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset coefficients: plain steps, restarts, back-to-back restarts
    pending_ticks = {1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    drain();

    // Everything at full scale: saturation on every path, colour capped
    v[REG_SIGMA]   = 32'hFFFF_FFFF;
    v[REG_RHO]     = 32'hFFFF_FFFF;
    v[REG_BETA]    = 32'hFFFF_FFFF;
    v[REG_DT]      = 32'hFFFF_FFFF;
    v[REG_START_X] = 32'h7FFF_FFFF;
    v[REG_START_Y] = 32'h8000_0000;
    v[REG_START_Z] = 32'h7FFF_FFFF;
    v[REG_GAIN]    = 32'hFFFF_FFFF;
    program_coefs(v);
    @(negedge clk_i);
    pending_ticks = {1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    drain();

    // All coefficients zero, start x at the negative rail
    v[REG_SIGMA]   = '0;
    v[REG_RHO]     = '0;
    v[REG_BETA]    = '0;
    v[REG_DT]      = '0;
    v[REG_START_X] = 32'h8000_0000;
    v[REG_START_Y] = '0;
    v[REG_START_Z] = 32'hFFFF_FFFF;
    v[REG_GAIN]    = '0;
    program_coefs(v);
    @(negedge clk_i);
    pending_ticks = {1'b0, 1'b1, 1'b0, 1'b0};
    drain();

    // Coarse time step with unit gain: colour both below and at the cap
    v[REG_SIGMA]   = 32'd167772160;
    v[REG_RHO]     = 32'd469762048;
    v[REG_BETA]    = 32'd44738124;
    v[REG_DT]      = 32'd1 << 20;
    v[REG_START_X] = 32'hFB00_0000;
    v[REG_START_Y] = 32'h0300_0000;
    v[REG_START_Z] = 32'h1400_0000;
    v[REG_GAIN]    = 32'd1 << FRAC;
    program_coefs(v);
    @(negedge clk_i);
    pending_ticks = {1'b1, 1'b0, 1'b0, 1'b0};
    drain();

    // Random settings, each followed by a run of ticks
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_random();
      @(negedge clk_i);
      idle_mode = (p % 3 != 2);
      if (p == 3) begin
        // stall the output long enough to back up the input
        hold_len = LONG_HOLD;
        hold_seq++;
      end
      pending_ticks.push_back(1'($urandom_range(0, 1)));
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (p == 6 && i == PHASE_TICKS / 2) drain();
        pending_ticks.push_back($urandom_range(0, 15) == 0);
      end
      drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      $error("%0d predicted results never arrived", expected_points.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
